[src/tnwu_pkg.sv]
// Shared types, constants and elaboration-time tables for the net weight update block.
// No dependencies; every other design file imports this package, the checker excepted.
package tnwu_pkg;

  localparam int LogTblBits  = 8;
  localparam int LogTblDepth = 1 << LogTblBits;
  localparam int ExpTblBits  = 8;
  localparam int ExpTblDepth = 1 << ExpTblBits;
  localparam int FracBits    = 20;

  localparam logic signed [31:0] SlackMax = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    CFG_WORST_SLACK,
    CFG_DECAY_FACTOR,
    CFG_WEIGHT_LIMIT,
    CFG_DEGREE_LIMIT
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOG1,
    ST_LOG2,
    ST_MIX,
    ST_SUM,
    ST_EXP,
    ST_WT,
    ST_OUT
  } back_st_e;

  typedef struct packed {
    logic signed [31:0] slack;
    logic [16:0]        crit;
    logic [31:0]        weight;
    logic [15:0]        degree;
  } net_t;

  typedef struct packed {
    logic signed [31:0] worst_slack;
    logic [16:0]        decay_factor;
    logic [31:0]        weight_limit;
    logic [15:0]        degree_limit;
  } cfg_t;

  typedef struct packed {
    logic [16:0]        crit;
    logic [31:0]        weight;
    logic signed [31:0] slack;
  } result_t;

  typedef logic [17:0] lt_tab_t [LogTblDepth+1];
  typedef logic [17:0] et_tab_t [ExpTblDepth+1];

  function automatic logic [63:0] isqrt(input logic [63:0] n0);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n0;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > n) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // log2(1 + i/depth) by repeated squaring of a Q30 mantissa
  function automatic lt_tab_t build_lt();
    lt_tab_t     t;
    logic [63:0] v;
    logic [63:0] r;
    for (int i = 0; i < LogTblDepth; i++) begin
      v = 64'(LogTblDepth + i) << (30 - LogTblBits);
      r = '0;
      for (int k = 1; k <= FracBits; k++) begin
        v = (v * v) >> 30;
        if (v >= (64'd2 << 30)) begin
          v = v >> 1;
          r = r | (64'd1 << (FracBits - k));
        end
      end
      t[i] = 18'((r + 64'd8) >> 4);
    end
    t[LogTblDepth] = 18'd65536;
    return t;
  endfunction

  // 2^(i/depth) as a product of repeated square roots of two
  function automatic et_tab_t build_et();
    et_tab_t     t;
    logic [63:0] roots [FracBits+1];
    logic [63:0] p;
    logic [63:0] f;
    roots[0] = 64'd2 << 30;
    for (int k = 1; k <= FracBits; k++) roots[k] = isqrt(roots[k-1] << 30);
    for (int i = 0; i < ExpTblDepth; i++) begin
      f = 64'(i) << (FracBits - ExpTblBits);
      p = 64'd1 << 30;
      for (int k = 1; k <= FracBits; k++) begin
        if (f[FracBits-k]) p = (p * roots[k]) >> 30;
      end
      t[i] = 18'((p + (64'd1 << 13)) >> 14);
    end
    t[ExpTblDepth] = 18'd131072;
    return t;
  endfunction

  localparam lt_tab_t LogTbl = build_lt();
  localparam et_tab_t ExpTbl = build_et();

endpackage

[src/timing_net_weight_update.sv]
// Top level of the timing-driven net weight update block.
// Depends on tnwu_pkg, tnwu_front, tnwu_fifo and tnwu_back.
//
// Pins stream in one per cycle; the front keeps the net's minimum slack and, on
// the pin flagged by tlast, queues the net (two-deep queue). The back sequencer
// then takes a net through log2, mix, sum and exp2 before the weight step when
// worst_slack is negative, and straight to the weight step when it is not; a net whose
// normalized slack is neither zero nor clamped first goes through the restoring
// divider. The output register hop comes on top. Pins of later nets keep streaming
// while the queue has room. A result is one transfer per net on the master side.
module timing_net_weight_update (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // slack_rise[31:0], slack_fall[63:32], old_criticality[80:64],
  // old_weight[112:81], net_degree[128:113], zero pad
  input  logic [135:0]  s_axis_tdata_i,
  // pin_present
  input  logic          s_axis_tuser_i,
  // pin_is_last
  input  logic          s_axis_tlast_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // new_criticality[16:0], new_weight[48:17], min_slack[80:49], zero pad
  output logic [87:0]   m_axis_tdata_o
);
  import tnwu_pkg::*;

  cfg_t    cfg_q;
  net_t    push_data, head;
  logic    push, pop, full, empty;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.worst_slack  <= '0;
      cfg_q.decay_factor <= 17'd32768;
      cfg_q.weight_limit <= '1;
      cfg_q.degree_limit <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WORST_SLACK:  cfg_q.worst_slack  <= cfg_data_i;
        CFG_DECAY_FACTOR: cfg_q.decay_factor <= cfg_data_i[16:0];
        CFG_WEIGHT_LIMIT: cfg_q.weight_limit <= cfg_data_i;
        CFG_DEGREE_LIMIT: cfg_q.degree_limit <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  tnwu_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .slack_rise_i     (s_axis_tdata_i[31:0]),
    .slack_fall_i     (s_axis_tdata_i[63:32]),
    .pin_present_i    (s_axis_tuser_i),
    .pin_is_last_i    (s_axis_tlast_i),
    .old_criticality_i(s_axis_tdata_i[80:64]),
    .old_weight_i     (s_axis_tdata_i[112:81]),
    .net_degree_i     (s_axis_tdata_i[128:113]),
    .q_full_i         (full),
    .q_push_o         (push),
    .q_data_o         (push_data)
  );

  tnwu_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (head)
  );

  tnwu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (empty),
    .q_data_i   (head),
    .q_pop_o    (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (res)
  );

  assign m_axis_tdata_o = {7'd0, res.slack, res.weight, res.crit};
endmodule

[src/tnwu_front.sv]
// Front end: per-net running minimum of pin slack; hands each finished net to the queue.
// Depends on tnwu_pkg.
module tnwu_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   slack_rise_i,
  input  logic signed [31:0]   slack_fall_i,
  input  logic                 pin_present_i,
  input  logic                 pin_is_last_i,
  input  logic [16:0]          old_criticality_i,
  input  logic [31:0]          old_weight_i,
  input  logic [15:0]          net_degree_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output tnwu_pkg::net_t       q_data_o
);
  import tnwu_pkg::*;

  logic signed [31:0] min_q, min_d;
  logic signed [31:0] pin_min;
  logic signed [31:0] net_min;
  logic               xfer;

  assign in_ready_o = !q_full_i;
  assign xfer       = in_valid_i && in_ready_o;
  assign pin_min    = (slack_rise_i < slack_fall_i) ? slack_rise_i : slack_fall_i;
  assign net_min    = (pin_present_i && pin_min < min_q) ? pin_min : min_q;

  always_comb begin
    min_d = min_q;
    if (xfer) min_d = pin_is_last_i ? SlackMax : net_min;
  end

  assign q_push_o        = xfer && pin_is_last_i;
  assign q_data_o.slack  = net_min;
  assign q_data_o.crit   = old_criticality_i;
  assign q_data_o.weight = old_weight_i;
  assign q_data_o.degree = net_degree_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= SlackMax;
    end else begin
      min_q <= min_d;
    end
  end
endmodule

[src/tnwu_fifo.sv]
// Two-entry queue of finished nets between front and back.
// Depends on tnwu_pkg.
module tnwu_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tnwu_pkg::net_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tnwu_pkg::net_t data_o
);
  import tnwu_pkg::*;

  net_t       mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_d;
    end
  end
endmodule

[src/tnwu_back.sv]
// Back end: sequencer for criticality (divide, log2, mix, exp2) and weight update,
// with the output register. Depends on tnwu_pkg tables and types.
module tnwu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tnwu_pkg::cfg_t     cfg_i,
  input  logic               q_empty_i,
  input  tnwu_pkg::net_t     q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tnwu_pkg::result_t  out_data_o
);
  import tnwu_pkg::*;

  localparam int LB = LogTblBits;
  localparam int EB = ExpTblBits;

  back_st_e    st_q, st_d;
  net_t        job_q;
  logic [32:0] rem_q;
  logic [15:0] quo_q;
  logic [3:0]  cnt_q;
  logic [16:0] nc_q;
  logic [17:0] l1_q, l2_q;
  logic [34:0] p1_q;
  logic [19:0] e_q;
  logic [16:0] crit_q;
  logic [31:0] wt_q;
  logic        ov_q;
  result_t     out_q;

  logic [31:0] wmag, head_mag;
  logic [33:0] rem2;
  logic        div_ge;
  logic [16:0] a_eff;
  logic        load_out;

  assign wmag     = 32'(-cfg_i.worst_slack);
  assign head_mag = 32'(-q_data_i.slack);
  assign rem2     = {rem_q, 1'b0};
  assign div_ge   = rem2 >= {2'b00, wmag};
  assign a_eff    = (cfg_i.decay_factor > 17'd65536) ? 17'd65536 : cfg_i.decay_factor;
  assign q_pop_o  = (st_q == ST_IDLE) && !q_empty_i;
  assign load_out = (st_q == ST_OUT) && (!ov_q || out_ready_i);

  // interpolated log2 of x in [1,4) Q16
  logic [17:0]          lx;
  logic                 lbig;
  logic [LB-1:0]        lidx;
  logic [LB:0]          lidx1;
  logic [16-LB:0]       lfrem;
  logic [17:0]          llo, lhi, ldiff;
  logic [34-LB:0]       lprod;
  logic [34-LB:0]       lsh;
  logic [17:0]          log_res;

  assign lx    = (st_q == ST_LOG1) ? 18'd65536 + 18'(job_q.crit) : 18'd65536 + 18'(nc_q);
  assign lbig  = lx[17];
  assign lidx  = lbig ? lx[16 -: LB] : lx[15 -: LB];
  assign lidx1 = {1'b0, lidx} + 1'b1;
  assign lfrem = lbig ? lx[16-LB:0] : {1'b0, lx[15-LB:0]};
  assign llo   = LogTbl[lidx];
  assign lhi   = LogTbl[lidx1];
  assign ldiff = (lhi < llo) ? 18'd0 : lhi - llo;
  assign lprod = (35-LB)'(ldiff * lfrem);
  assign lsh   = lbig ? (lprod >> (17 - LB)) : (lprod >> (16 - LB));
  assign log_res = (lbig ? 18'd65536 : 18'd0) + llo + 18'(lsh);

  // interpolated exp2
  logic [EB-1:0]  eidx;
  logic [EB:0]    eidx1;
  logic [15-EB:0] efrem;
  logic [17:0]    elo, ehi, ediff;
  logic [33-EB:0] eprod;
  logic [17:0]    em0;
  logic [20:0]    em;
  logic [16:0]    crit_new;

  assign eidx  = e_q[15 -: EB];
  assign eidx1 = {1'b0, eidx} + 1'b1;
  assign efrem = e_q[15-EB:0];
  assign elo   = ExpTbl[eidx];
  assign ehi   = ExpTbl[eidx1];
  assign ediff = (ehi < elo) ? 18'd0 : ehi - elo;
  assign eprod = (34-EB)'(ediff * efrem);
  assign em0   = elo + 18'(eprod >> (16 - EB));
  assign em    = {3'b000, em0} << e_q[17:16];

  always_comb begin
    if (em <= 21'd65536) crit_new = 17'd0;
    else if (em - 21'd65536 > 21'd131071) crit_new = 17'd131071;
    else crit_new = 17'(em - 21'd65536);
  end

  logic [35:0] sum;
  logic [49:0] wprod;
  logic [33:0] wscaled;
  assign sum     = 36'(p1_q) + 36'((17'd65536 - a_eff) * l2_q) + 36'd32768;
  assign wprod   = job_q.weight * (18'd65536 + 18'(crit_q));
  assign wscaled = wprod[49:16];

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (!cfg_i.worst_slack[31]) st_d = ST_WT;
          else if (!q_data_i.slack[31] || head_mag >= wmag) st_d = ST_LOG1;
          else st_d = ST_DIV;
        end
      end
      ST_DIV:  if (cnt_q == 4'd15) st_d = ST_LOG1;
      ST_LOG1: st_d = ST_LOG2;
      ST_LOG2: st_d = ST_MIX;
      ST_MIX:  st_d = ST_SUM;
      ST_SUM:  st_d = ST_EXP;
      ST_EXP:  st_d = ST_WT;
      ST_WT:   st_d = ST_OUT;
      ST_OUT:  if (load_out) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        job_q  <= q_data_i;
        crit_q <= q_data_i.crit;
        rem_q  <= {1'b0, head_mag};
        cnt_q  <= 4'd0;
        if (!q_data_i.slack[31]) nc_q <= 17'd0;
        else nc_q <= 17'd65536;
      end
      ST_DIV: begin
        rem_q <= div_ge ? 33'(rem2 - {2'b00, wmag}) : rem2[32:0];
        quo_q <= {quo_q[14:0], div_ge};
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) nc_q <= {1'b0, quo_q[14:0], div_ge};
      end
      ST_LOG1: l1_q <= log_res;
      ST_LOG2: l2_q <= log_res;
      ST_MIX:  p1_q <= 35'(a_eff * l1_q);
      ST_SUM:  e_q <= sum[35:16];
      ST_EXP:  crit_q <= crit_new;
      ST_WT: begin
        if (job_q.degree > cfg_i.degree_limit) wt_q <= job_q.weight;
        else if (wscaled > {2'b00, cfg_i.weight_limit}) wt_q <= cfg_i.weight_limit;
        else wt_q <= wscaled[31:0];
      end
      ST_OUT: begin
        if (load_out) begin
          out_q.crit   <= crit_q;
          out_q.weight <= wt_q;
          out_q.slack  <= job_q.slack;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
endmodule

[src/tnwu_checker.sv]
// Port-level checker for timing_net_weight_update, attached by bind.
// Depends only on the top level's ports.
module tnwu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         s_axis_tlast_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [87:0]  m_axis_tdata_o
);
  logic [3:0] nets_q;
  logic       in_net, out_xfer;

  assign in_net   = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nets_q <= 4'd0;
    end else begin
      nets_q <= nets_q + {3'd0, in_net} - {3'd0, out_xfer};
    end
  end

  // a result only for a net whose last pin went in
  a_result_has_net: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> nets_q != 4'd0)
    else $error("result without a finished net");

  // never more nets pending than queue, sequencer and output register hold
  a_bounded_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nets_q <= 4'd4)
    else $error("too many nets in flight");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");
endmodule

bind timing_net_weight_update tnwu_checker u_tnwu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tlast_i (s_axis_tlast_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
